### rtl/sdspi_pkg.sv
// Shared types, codes and constants for the SD card SPI transaction engine.
package sdspi_pkg;

  // Sector size and the byte counter that walks it
  localparam int BLOCK_BYTES = 512;
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam logic [CNT_W-1:0] BLOCK_CNT = CNT_W'(BLOCK_BYTES);

  // Frame and token bytes
  localparam logic [7:0] CMD_START   = 8'h40;
  localparam logic [7:0] CMD_CRC     = 8'h95;
  localparam logic [5:0] CMD_STOP    = 6'h0c;
  localparam logic [5:0] CMD_READ    = 6'd17;
  localparam logic [5:0] CMD_WRITE   = 6'd24;
  localparam logic [7:0] R1_ERR_MASK = 8'hc0;
  localparam logic [7:0] DATA_TOKEN  = 8'hfe;
  localparam logic [7:0] DRESP_MASK  = 8'h1f;
  localparam logic [7:0] DRESP_OK    = 8'h05;
  localparam logic [7:0] IDLE_BYTE   = 8'hff;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_READY_RETRY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_RETRY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOKEN_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROTECT     = 3'd4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_COMMAND = 2'd0,
    OP_READ    = 2'd1,
    OP_WRITE   = 2'd2,
    OP_XFER    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_READY   = 3'd1,
    ST_NO_RESPONSE = 3'd2,
    ST_REJECTED    = 3'd3,
    ST_TOKEN_TMO   = 3'd4,
    ST_WR_REFUSED  = 3'd5,
    ST_PROTECTED   = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_PRE, PH_READY, PH_FRAME, PH_EXTRA, PH_RESP, PH_TOKEN, PH_RDATA,
    PH_RCRC, PH_RTAIL, PH_WGAP, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY
  } phase_t;

  typedef struct packed {
    logic [7:0]  ready_retry_limit;
    logic [7:0]  response_retry_limit;
    logic [15:0] token_limit;
    logic [15:0] busy_limit;
    logic        protect_sector_zero;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select;
    logic       data_taken;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    status_t    status;
    logic [7:0] response;
  } result_t;

endpackage

### rtl/sd_spi_transaction_engine.sv
// Top level: stream ports, input register, sequencer and result register.
//
// SD card SPI-mode host engine. Send a request (raw command, sector read or
// sector write) and then one item per SPI byte exchange carrying the byte just
// received; each item returns exactly one result with the next byte to send,
// the chip-select level, read data and completion status. One item is taken
// per clock cycle while the result side is not stalled; an accepted item sits
// in the input register and its result is loaded into the result register
// once that register can take it, and backpressure on the result side holds
// the input side. The phase sequencer updates its state in the same cycle the
// result is formed, so consecutive items chain without gaps.
// No start-up or card initialisation is performed; software issues the raw
// commands for that. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while no transaction is in flight; the block does not enforce this.
module sd_spi_transaction_engine
  import sdspi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [55:0]           s_tdata,   // command_index, argument, rx_byte, write_byte
  input  logic [1:0]            s_tuser,   // operation
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // tx_byte, chip_select, data_taken, read_byte,
                                           // status, response
  output logic [2:0]            m_tuser,   // tx_valid, read_valid, done_res
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    step_en;
  result_t res;
  result_t res_q;

  sdspi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the stage moves when the result register can take it
  assign step_en  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || step_en;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.operation     <= op_t'(s_tuser);
      item.command_index <= s_tdata[5:0];
      item.argument      <= s_tdata[37:6];
      item.rx_byte       <= s_tdata[45:38];
      item.write_byte    <= s_tdata[53:46];
    end
  end

  sdspi_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) res_q <= res;
  end

  assign m_tdata = {3'd0, res_q.response, res_q.status, res_q.read_byte,
                    res_q.data_taken, res_q.chip_select, res_q.tx_byte};
  assign m_tuser = {res_q.done_res, res_q.read_valid, res_q.tx_valid};

endmodule

### rtl/sdspi_cfg.sv
// Configuration register file with reset values.
module sdspi_cfg
  import sdspi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Write decoder; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_retry_limit    <= 8'd10;
      cfg.response_retry_limit <= 8'd10;
      cfg.token_limit          <= 16'd100;
      cfg.busy_limit           <= 16'd0;
      cfg.protect_sector_zero  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_READY_RETRY: cfg.ready_retry_limit    <= cfg_data[7:0];
        REG_RESP_RETRY:  cfg.response_retry_limit <= cfg_data[7:0];
        REG_TOKEN_LIMIT: cfg.token_limit          <= cfg_data;
        REG_BUSY_LIMIT:  cfg.busy_limit           <= cfg_data;
        REG_PROTECT:     cfg.protect_sector_zero  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/sdspi_core.sv
// Transaction sequencer: phase state and per-exchange next-byte logic.
module sdspi_core
  import sdspi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step_en,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t           phase, phase_next;
  op_t              transfer_kind, transfer_kind_next;
  logic [47:0]      frame_shift, frame_shift_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      poll_count, poll_count_next;
  logic             stop_extra, stop_extra_next;

  // State registers, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      transfer_kind <= OP_COMMAND;
      frame_shift   <= '0;
      byte_count    <= '0;
      poll_count    <= '0;
      stop_extra    <= 1'b0;
    end else if (step_en) begin
      phase         <= phase_next;
      transfer_kind <= transfer_kind_next;
      frame_shift   <= frame_shift_next;
      byte_count    <= byte_count_next;
      poll_count    <= poll_count_next;
      stop_extra    <= stop_extra_next;
    end
  end

  // Next state and result for one item
  always_comb begin
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [CNT_W-1:0] bc_inc;

    phase_next         = phase;
    transfer_kind_next = transfer_kind;
    frame_shift_next   = frame_shift;
    byte_count_next    = byte_count;
    poll_count_next    = poll_count;
    stop_extra_next    = stop_extra;
    bc_inc             = byte_count + 1'b1;

    res          = '0;
    res.tx_byte  = IDLE_BYTE;
    res.status   = ST_OK;

    cmd = item.command_index;
    arg = item.argument;
    if (item.operation == OP_READ) begin
      cmd = CMD_READ;
      arg = {item.argument[22:0], 9'd0};
    end else if (item.operation == OP_WRITE) begin
      cmd = CMD_WRITE;
      arg = {item.argument[22:0], 9'd0};
    end

    if (item.operation != OP_XFER) begin
      // New request: abandons anything running
      if (item.operation == OP_WRITE && cfg.protect_sector_zero &&
          item.argument == 32'd0) begin
        res.done_res = 1'b1;
        res.status   = ST_PROTECTED;
        phase_next   = PH_IDLE;
      end else begin
        transfer_kind_next = item.operation;
        stop_extra_next    = (cmd == CMD_STOP);
        frame_shift_next   = {CMD_START | {2'b00, cmd}, arg, CMD_CRC};
        byte_count_next    = '0;
        poll_count_next    = '0;
        phase_next         = PH_PRE;
        res.tx_valid       = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_PRE: begin
          phase_next      = PH_READY;
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
        end
        PH_READY: begin
          if (item.rx_byte == IDLE_BYTE) begin
            phase_next       = PH_FRAME;
            res.tx_byte      = frame_shift[47:40];
            res.tx_valid     = 1'b1;
            res.chip_select  = 1'b1;
            frame_shift_next = {frame_shift[39:0], 8'd0};
            byte_count_next  = CNT_W'(1);
          end else if (poll_count >= {8'd0, cfg.ready_retry_limit}) begin
            res.done_res = 1'b1;
            res.status   = ST_NOT_READY;
            phase_next   = PH_IDLE;
          end else begin
            poll_count_next = poll_count + 16'd1;
            res.tx_valid    = 1'b1;
            res.chip_select = 1'b1;
          end
        end
        PH_FRAME: begin
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
          if (byte_count < CNT_W'(6)) begin
            res.tx_byte      = frame_shift[47:40];
            frame_shift_next = {frame_shift[39:0], 8'd0};
            byte_count_next  = bc_inc;
          end else begin
            phase_next      = stop_extra ? PH_EXTRA : PH_RESP;
            poll_count_next = '0;
          end
        end
        PH_EXTRA: begin
          phase_next      = PH_RESP;
          poll_count_next = '0;
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
        end
        PH_RESP: begin
          // Poll limit is checked before the byte is looked at
          if (poll_count >= {8'd0, cfg.response_retry_limit}) begin
            res.done_res = 1'b1;
            res.status   = ST_NO_RESPONSE;
            res.response = item.rx_byte;
            phase_next   = PH_IDLE;
          end else begin
            poll_count_next = poll_count + 16'd1;
            if ((item.rx_byte & R1_ERR_MASK) != 8'd0) begin
              res.tx_valid    = 1'b1;
              res.chip_select = 1'b1;
            end else if (transfer_kind == OP_COMMAND) begin
              res.done_res = 1'b1;
              res.response = item.rx_byte;
              phase_next   = PH_IDLE;
            end else if (item.rx_byte != 8'd0) begin
              res.done_res = 1'b1;
              res.status   = ST_REJECTED;
              res.response = item.rx_byte;
              phase_next   = PH_IDLE;
            end else if (transfer_kind == OP_READ) begin
              phase_next      = PH_TOKEN;
              poll_count_next = '0;
              res.tx_valid    = 1'b1;
              res.chip_select = 1'b1;
            end else begin
              phase_next      = PH_WGAP;
              byte_count_next = CNT_W'(1);
              res.tx_valid    = 1'b1;
              res.chip_select = 1'b1;
            end
          end
        end
        PH_TOKEN: begin
          if (item.rx_byte == DATA_TOKEN) begin
            phase_next      = PH_RDATA;
            byte_count_next = '0;
            res.tx_valid    = 1'b1;
            res.chip_select = 1'b1;
          end else if (cfg.token_limit != 16'd0 && poll_count >= cfg.token_limit) begin
            res.done_res = 1'b1;
            res.status   = ST_TOKEN_TMO;
            phase_next   = PH_IDLE;
          end else begin
            if (cfg.token_limit != 16'd0) poll_count_next = poll_count + 16'd1;
            res.tx_valid    = 1'b1;
            res.chip_select = 1'b1;
          end
        end
        PH_RDATA: begin
          res.read_byte   = item.rx_byte;
          res.read_valid  = 1'b1;
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
          if (bc_inc >= BLOCK_CNT) begin
            phase_next      = PH_RCRC;
            byte_count_next = '0;
          end else begin
            byte_count_next = bc_inc;
          end
        end
        PH_RCRC: begin
          res.tx_valid = 1'b1;
          if (byte_count == '0) begin
            byte_count_next = CNT_W'(1);
            res.chip_select = 1'b1;
          end else begin
            phase_next = PH_RTAIL;
          end
        end
        PH_RTAIL: begin
          res.done_res = 1'b1;
          phase_next   = PH_IDLE;
        end
        PH_WGAP: begin
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
          if (byte_count < CNT_W'(3)) begin
            byte_count_next = bc_inc;
          end else begin
            phase_next  = PH_WTOKEN;
            res.tx_byte = DATA_TOKEN;
          end
        end
        PH_WTOKEN: begin
          phase_next      = PH_WDATA;
          byte_count_next = CNT_W'(1);
          res.data_taken  = 1'b1;
          res.tx_byte     = item.write_byte;
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
        end
        PH_WDATA: begin
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
          if (byte_count < BLOCK_CNT) begin
            byte_count_next = bc_inc;
            res.data_taken  = 1'b1;
            res.tx_byte     = item.write_byte;
          end else begin
            phase_next      = PH_WCRC;
            byte_count_next = '0;
          end
        end
        PH_WCRC: begin
          res.tx_valid    = 1'b1;
          res.chip_select = 1'b1;
          if (byte_count == '0) byte_count_next = CNT_W'(1);
          else phase_next = PH_WRESP;
        end
        PH_WRESP: begin
          if ((item.rx_byte & DRESP_MASK) != DRESP_OK) begin
            res.done_res = 1'b1;
            res.status   = ST_WR_REFUSED;
            res.response = item.rx_byte;
            phase_next   = PH_IDLE;
          end else begin
            frame_shift_next = {40'd0, item.rx_byte};
            phase_next       = PH_BUSY;
            poll_count_next  = '0;
            res.tx_valid     = 1'b1;
            res.chip_select  = 1'b1;
          end
        end
        PH_BUSY: begin
          // Card holds the line low while it programs the block
          if (item.rx_byte != 8'd0) begin
            res.done_res = 1'b1;
            res.response = frame_shift[7:0];
            phase_next   = PH_IDLE;
          end else if (cfg.busy_limit != 16'd0 && poll_count >= cfg.busy_limit) begin
            res.done_res = 1'b1;
            res.status   = ST_NOT_READY;
            res.response = frame_shift[7:0];
            phase_next   = PH_IDLE;
          end else begin
            if (cfg.busy_limit != 16'd0) poll_count_next = poll_count + 16'd1;
            res.tx_valid    = 1'b1;
            res.chip_select = 1'b1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

endmodule
